// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the catalog lookup block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MCL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MCL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mcl_pkg.sv =====
// ----------------------------------------------------------------------------
// mcl_pkg
// Types, codes and constants shared by the catalog hash lookup modules.
// ----------------------------------------------------------------------------
package mcl_pkg;

   // Default sizes
   localparam int IMAGE_BYTES_DEF = 65536;
   localparam int MAX_KEY_DEF     = 256;

   // Catalog format constants
   localparam logic [31:0] MO_MAGIC      = 32'h950412DE;
   localparam logic [31:0] MO_MAGIC_SWAP = 32'hDE120495;
   localparam logic [31:0] NIBBLE_MASK   = 32'h0000000F;
   localparam int          WORD_BITS     = 32;
   localparam logic [31:0] HDR_KEY_TAB   = 32'd12;
   localparam logic [31:0] HDR_VAL_TAB   = 32'd16;
   localparam logic [31:0] HDR_HASH_SIZE = 32'd20;
   localparam logic [31:0] HDR_HASH_TAB  = 32'd24;
   localparam logic [31:0] MIN_HASH_SIZE = 32'd3;
   localparam int          INDEX_W       = 13;

   // Operation codes
   localparam logic [1:0] OP_WRITE  = 2'd0;
   localparam logic [1:0] OP_KEY    = 2'd1;
   localparam logic [1:0] OP_HEADER = 2'd2;

   // Result kinds and header status codes
   localparam logic       KIND_HEADER   = 1'b0;
   localparam logic       KIND_LOOKUP   = 1'b1;
   localparam logic [1:0] ST_VALID      = 2'd0;
   localparam logic [1:0] ST_BAD_MAGIC  = 2'd1;
   localparam logic [1:0] ST_SMALL_HASH = 2'd2;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] address;
      logic [7:0]  data_byte;
      logic        last;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic [1:0]         status;
      logic               found;
      logic [INDEX_W-1:0] entry_index;
      logic [31:0]        value_offset;
      logic               key_overflow;
   } rsp_type;

   // Which word the word reader fetches, and where it lands
   typedef enum logic [2:0] {
      W_MAGIC, W_KEY_TAB, W_VAL_TAB, W_HASH_SIZE, W_HASH_TAB, W_SLOT, W_KEY_OFF, W_VAL_OFF
   } wsel_type;

   // Divider operand choice
   typedef enum logic {
      DIV_SIZE, DIV_SIZE_M2
   } dsel_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_H_MAGIC, S_H_MCHK, S_H_KT, S_H_VT, S_H_HS, S_H_HB,
      S_H_OK, S_H_BAD, S_H_SMALL,
      S_L_START, S_L_DIV1, S_L_DIV2, S_L_SLOT, S_L_SCHK, S_L_KOFF,
      S_L_CMP, S_L_ADV, S_L_VOFF, S_L_HIT, S_L_MISS
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       accept;
      logic       word_req;
      wsel_type   word_sel;
      logic       div_req;
      dsel_type   div_sel;
      logic       cmp_req;
      logic       adv;
      logic       swap_set;
      logic       cat_clear;
      logic       cat_set;
      logic       key_clear;
      logic       emit;
      logic       kind;
      logic [1:0] status;
      logic       found;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic word_done;
      logic div_done;
      logic cmp_done;
      logic cmp_match;
      logic magic_ok;
      logic hs_small;
      logic lookup_ok;
      logic slot_empty;
      logic probe_end;
   } sts_type;

endpackage

// ===== src/mcl_ram.sv =====
// ----------------------------------------------------------------------------
// mcl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mcl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/mcl_dp.sv =====
// ----------------------------------------------------------------------------
// mcl_dp
// Datapath: image and key stores, header registers, key hashing, word reader,
// remainder divider, key comparator and probe cursor.
// ----------------------------------------------------------------------------
module mcl_dp #(
   parameter int IMAGE_BYTES = mcl_pkg::IMAGE_BYTES_DEF,
   parameter int MAX_KEY     = mcl_pkg::MAX_KEY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  mcl_pkg::req_type req_data,
   input  mcl_pkg::cmd_type cmd,
   output mcl_pkg::sts_type sts,
   output mcl_pkg::rsp_type rsp_data
);
   import mcl_pkg::*;

   localparam int AW  = $clog2(IMAGE_BYTES);
   localparam int KAW = $clog2(MAX_KEY);
   localparam int KLW = $clog2(MAX_KEY + 1);

   // PJW hash step over one byte.
   function automatic logic [31:0] pjw(input logic [31:0] h_in, input logic [7:0] b);
      logic [31:0] h;
      logic [31:0] g;
      h = (h_in << 4) + {24'd0, b};
      g = h & (NIBBLE_MASK << (WORD_BITS - 4));
      if (g != 32'd0) begin
         h = h ^ (g >> (WORD_BITS - 8));
         h = h ^ g;
      end
      return h;
   endfunction

   // Catalog registers
   logic        valid_ff, swapped_ff;
   logic [31:0] kt_ff, vt_ff, hs_ff, hb_ff;
   // Key registers
   logic [KLW-1:0] key_len_ff;
   logic [31:0]    hash_ff;
   logic           ended_ff, over_ff;
   // Word reader
   logic        rd_active_ff, rd_done_ff;
   logic [2:0]  rd_cnt_ff;
   logic [31:0] rd_base_ff, word_ff, word_in;
   wsel_type    rd_sel_ff;
   logic [31:0] rd_base_in;
   logic [1:0]  byte_idx;
   // Divider
   logic        div_active_ff, div_done_ff;
   logic [4:0]  div_cnt_ff;
   logic [31:0] div_rem_ff, div_dvd_ff, div_dsr_ff, div_rem_in;
   dsel_type    div_sel_ff;
   logic [32:0] div_sh;
   // Comparator
   logic           cmp_active_ff, cmp_check_ff, cmp_done_ff, cmp_match_ff;
   logic [KLW-1:0] cmp_i_ff;
   logic [31:0]    cmp_off_ff;
   logic [7:0]     cmp_exp;
   // Probe state
   logic [31:0] cursor_ff, start_ff, inc_ff, steps_ff, entry_ff, voff_ff;
   logic [32:0] cur_sum, steps_in;
   logic [31:0] cursor_in;
   // Memory ports
   logic [31:0] img_rd_addr;
   logic        img_oob_ff;
   logic [7:0]  img_q, img_byte, key_q;
   logic        img_we, key_we;
   logic [31:0] wr_addr32;

   // Accepted image write or key byte.
   assign wr_addr32 = {16'd0, req_data.address};
   assign img_we = cmd.accept && (req_data.op == OP_WRITE)
                   && ({1'b0, wr_addr32} < 33'(IMAGE_BYTES));
   assign key_we = cmd.accept && (req_data.op == OP_KEY) && (req_data.data_byte != 8'd0)
                   && !ended_ff && (key_len_ff < KLW'(MAX_KEY));

   // Image read address: comparator when active, otherwise the word reader.
   assign img_rd_addr = cmp_active_ff ? (cmp_off_ff + 32'(cmp_i_ff))
                                      : (rd_base_ff + 32'(rd_cnt_ff));

   mcl_ram #(.WIDTH(8), .DEPTH(IMAGE_BYTES)) u_image (
      .clock   (clock),
      .wr_en   (img_we),
      .wr_addr (wr_addr32[AW-1:0]),
      .wr_data (req_data.data_byte),
      .rd_addr (img_rd_addr[AW-1:0]),
      .rd_data (img_q)
   );

   mcl_ram #(.WIDTH(8), .DEPTH(MAX_KEY)) u_key (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (key_len_ff[KAW-1:0]),
      .wr_data (req_data.data_byte),
      .rd_addr (cmp_i_ff[KAW-1:0]),
      .rd_data (key_q)
   );

   // Bytes outside the image read as zero.
   always_ff @(posedge clock) begin
      img_oob_ff <= ({1'b0, img_rd_addr} >= 33'(IMAGE_BYTES));
   end
   assign img_byte = img_oob_ff ? 8'd0 : img_q;

   // Catalog registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         swapped_ff <= 1'b0;
         kt_ff      <= '0;
         vt_ff      <= '0;
         hs_ff      <= '0;
         hb_ff      <= '0;
      end else begin
         if (cmd.accept && (req_data.op == OP_WRITE)) begin
            valid_ff <= 1'b0;
         end
         if (cmd.accept && (req_data.op == OP_HEADER)) begin
            swapped_ff <= 1'b0;
         end
         if (cmd.swap_set) begin
            swapped_ff <= (word_ff == MO_MAGIC_SWAP);
         end
         if (rd_active_ff && (rd_cnt_ff == 3'd4)) begin
            unique case (rd_sel_ff)
               W_KEY_TAB:   kt_ff <= word_in;
               W_VAL_TAB:   vt_ff <= word_in;
               W_HASH_SIZE: hs_ff <= word_in;
               W_HASH_TAB:  hb_ff <= word_in;
               default: ;
            endcase
         end
         if (cmd.cat_set) begin
            valid_ff <= 1'b1;
         end
         if (cmd.cat_clear) begin
            valid_ff   <= 1'b0;
            swapped_ff <= 1'b0;
            kt_ff      <= '0;
            vt_ff      <= '0;
            hs_ff      <= '0;
            hb_ff      <= '0;
         end
      end
   end

   // Key buffering and running hash.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_len_ff <= '0;
         hash_ff    <= '0;
         ended_ff   <= 1'b0;
         over_ff    <= 1'b0;
      end else if (cmd.key_clear) begin
         key_len_ff <= '0;
         hash_ff    <= '0;
         ended_ff   <= 1'b0;
         over_ff    <= 1'b0;
      end else if (cmd.accept && (req_data.op == OP_KEY)) begin
         if (req_data.data_byte == 8'd0) begin
            ended_ff <= 1'b1;
         end else if (!ended_ff) begin
            if (key_len_ff >= KLW'(MAX_KEY)) begin
               over_ff <= 1'b1;
            end else begin
               key_len_ff <= key_len_ff + KLW'(1);
               hash_ff    <= pjw(hash_ff, req_data.data_byte);
            end
         end
      end
   end

   // Word reader: four byte reads, assembled in the catalog's byte order.
   always_comb begin
      unique case (cmd.word_sel)
         W_MAGIC:     rd_base_in = 32'd0;
         W_KEY_TAB:   rd_base_in = HDR_KEY_TAB;
         W_VAL_TAB:   rd_base_in = HDR_VAL_TAB;
         W_HASH_SIZE: rd_base_in = HDR_HASH_SIZE;
         W_HASH_TAB:  rd_base_in = HDR_HASH_TAB;
         W_SLOT:      rd_base_in = hb_ff + {cursor_ff[29:0], 2'b00};
         W_KEY_OFF:   rd_base_in = kt_ff + {entry_ff[28:0], 3'b000} + 32'd4;
         W_VAL_OFF:   rd_base_in = vt_ff + {entry_ff[28:0], 3'b000} + 32'd4;
         default:     rd_base_in = 32'd0;
      endcase
   end

   assign byte_idx = 2'(rd_cnt_ff - 3'd1);

   always_comb begin
      word_in = word_ff;
      if (rd_active_ff && (rd_cnt_ff != 3'd0)) begin
         if (swapped_ff) begin
            word_in = {word_ff[23:0], img_byte};
         end else begin
            word_in[8*byte_idx +: 8] = img_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_active_ff <= 1'b0;
         rd_done_ff   <= 1'b0;
         rd_cnt_ff    <= '0;
      end else begin
         rd_done_ff <= rd_active_ff && (rd_cnt_ff == 3'd4);
         if (rd_active_ff) begin
            if (rd_cnt_ff == 3'd4) begin
               rd_active_ff <= 1'b0;
            end
            rd_cnt_ff <= rd_cnt_ff + 3'd1;
         end else if (cmd.word_req && !rd_done_ff) begin
            rd_active_ff <= 1'b1;
            rd_cnt_ff    <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!rd_active_ff && cmd.word_req && !rd_done_ff) begin
         rd_base_ff <= rd_base_in;
         rd_sel_ff  <= cmd.word_sel;
         word_ff    <= '0;
      end else begin
         word_ff <= word_in;
      end
      if (rd_active_ff && (rd_cnt_ff == 3'd4)) begin
         if (rd_sel_ff == W_SLOT) begin
            entry_ff <= word_in - 32'd1;
         end
         if (rd_sel_ff == W_VAL_OFF) begin
            voff_ff <= word_in;
         end
      end
   end

   // Restoring divider, one quotient bit a cycle; only the remainder is kept.
   assign div_sh     = {div_rem_ff, div_dvd_ff[31]};
   assign div_rem_in = (div_sh >= {1'b0, div_dsr_ff}) ? 32'(div_sh - {1'b0, div_dsr_ff})
                                                      : div_sh[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         div_active_ff <= 1'b0;
         div_done_ff   <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         div_done_ff <= div_active_ff && (div_cnt_ff == 5'd31);
         if (div_active_ff) begin
            div_cnt_ff <= div_cnt_ff + 5'd1;
            if (div_cnt_ff == 5'd31) begin
               div_active_ff <= 1'b0;
            end
         end else if (cmd.div_req && !div_done_ff) begin
            div_active_ff <= 1'b1;
            div_cnt_ff    <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!div_active_ff && cmd.div_req && !div_done_ff) begin
         div_rem_ff <= '0;
         div_dvd_ff <= hash_ff;
         div_dsr_ff <= (cmd.div_sel == DIV_SIZE) ? hs_ff : (hs_ff - 32'd2);
         div_sel_ff <= cmd.div_sel;
      end else if (div_active_ff) begin
         div_rem_ff <= div_rem_in;
         div_dvd_ff <= {div_dvd_ff[30:0], 1'b0};
      end
   end

   // Probe cursor: first slot and step from the divider, then modular stepping.
   assign cur_sum   = {1'b0, cursor_ff} + {1'b0, inc_ff};
   assign cursor_in = (cur_sum >= {1'b0, hs_ff}) ? 32'(cur_sum - {1'b0, hs_ff})
                                                 : cur_sum[31:0];
   assign steps_in  = {1'b0, steps_ff} + 33'd1;

   always_ff @(posedge clock) begin
      if (div_active_ff && (div_cnt_ff == 5'd31)) begin
         if (div_sel_ff == DIV_SIZE) begin
            cursor_ff <= div_rem_in;
            start_ff  <= div_rem_in;
         end else begin
            inc_ff   <= div_rem_in + 32'd1;
            steps_ff <= '0;
         end
      end else if (cmd.adv) begin
         cursor_ff <= cursor_in;
         steps_ff  <= steps_in[31:0];
      end
   end

   // Key comparator: a fetch step and a check step per stored byte, ending at the NUL or at the first mismatch.
   assign cmp_exp = (cmp_i_ff < key_len_ff) ? key_q : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cmp_active_ff <= 1'b0;
         cmp_check_ff  <= 1'b0;
         cmp_done_ff   <= 1'b0;
         cmp_match_ff  <= 1'b0;
      end else begin
         cmp_done_ff <= cmp_active_ff && cmp_check_ff
                        && ((img_byte != cmp_exp) || (cmp_i_ff == key_len_ff));
         if (cmp_active_ff) begin
            if (!cmp_check_ff) begin
               cmp_check_ff <= 1'b1;
            end else if (img_byte != cmp_exp) begin
               cmp_active_ff <= 1'b0;
               cmp_match_ff  <= 1'b0;
            end else if (cmp_i_ff == key_len_ff) begin
               cmp_active_ff <= 1'b0;
               cmp_match_ff  <= 1'b1;
            end else begin
               cmp_check_ff <= 1'b0;
            end
         end else if (cmd.cmp_req && !cmp_done_ff) begin
            cmp_active_ff <= 1'b1;
            cmp_check_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!cmp_active_ff && cmd.cmp_req && !cmp_done_ff) begin
         cmp_i_ff   <= '0;
         cmp_off_ff <= word_ff;
      end else if (cmp_active_ff && cmp_check_ff && (img_byte == cmp_exp)
                   && (cmp_i_ff != key_len_ff)) begin
         cmp_i_ff <= cmp_i_ff + KLW'(1);
      end
   end

   // Status towards the controller.
   assign sts.word_done  = rd_done_ff;
   assign sts.div_done   = div_done_ff;
   assign sts.cmp_done   = cmp_done_ff;
   assign sts.cmp_match  = cmp_match_ff;
   assign sts.magic_ok   = (word_ff == MO_MAGIC) || (word_ff == MO_MAGIC_SWAP);
   assign sts.hs_small   = (hs_ff < MIN_HASH_SIZE);
   assign sts.lookup_ok  = valid_ff && !over_ff && (hs_ff >= MIN_HASH_SIZE);
   assign sts.slot_empty = (word_ff == 32'd0);
   assign sts.probe_end  = (cursor_in == start_ff) || (steps_in >= {1'b0, hs_ff});

   // Result fields.
   always_comb begin
      rsp_data.kind         = cmd.kind;
      rsp_data.status       = cmd.status;
      rsp_data.found        = cmd.found;
      rsp_data.entry_index  = cmd.found ? entry_ff[INDEX_W-1:0] : '0;
      rsp_data.value_offset = cmd.found ? voff_ff : 32'd0;
      rsp_data.key_overflow = (cmd.kind == KIND_LOOKUP) ? over_ff : 1'b0;
   end

endmodule

// ===== src/mcl_ctrl.sv =====
// ----------------------------------------------------------------------------
// mcl_ctrl
// Controller: sequences the header check and the hash probe over the datapath.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mcl_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mcl_pkg::req_type req_data,
   input  mcl_pkg::sts_type sts,
   output mcl_pkg::cmd_type cmd,
   output logic             busy
);
   import mcl_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.op == OP_HEADER) begin
                  state_in = S_H_MAGIC;
               end else if ((req_data.op == OP_KEY) && req_data.last) begin
                  state_in = S_L_START;
               end
            end
         end
         S_H_MAGIC: if (sts.word_done) state_in = S_H_MCHK;
         S_H_MCHK:  state_in = sts.magic_ok ? S_H_KT : S_H_BAD;
         S_H_KT:    if (sts.word_done) state_in = S_H_VT;
         S_H_VT:    if (sts.word_done) state_in = S_H_HS;
         S_H_HS:    if (sts.word_done) state_in = S_H_HB;
         S_H_HB: begin
            if (sts.word_done) state_in = sts.hs_small ? S_H_SMALL : S_H_OK;
         end
         S_H_OK, S_H_BAD, S_H_SMALL: state_in = S_IDLE;
         S_L_START: state_in = sts.lookup_ok ? S_L_DIV1 : S_L_MISS;
         S_L_DIV1:  if (sts.div_done) state_in = S_L_DIV2;
         S_L_DIV2:  if (sts.div_done) state_in = S_L_SLOT;
         S_L_SLOT:  if (sts.word_done) state_in = S_L_SCHK;
         S_L_SCHK:  state_in = sts.slot_empty ? S_L_MISS : S_L_KOFF;
         S_L_KOFF:  if (sts.word_done) state_in = S_L_CMP;
         S_L_CMP: begin
            if (sts.cmp_done) state_in = sts.cmp_match ? S_L_VOFF : S_L_ADV;
         end
         S_L_ADV:   state_in = sts.probe_end ? S_L_MISS : S_L_SLOT;
         S_L_VOFF:  if (sts.word_done) state_in = S_L_HIT;
         S_L_HIT, S_L_MISS: state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Commands to the datapath.
   always_comb begin
      cmd          = '0;
      cmd.word_sel = W_MAGIC;
      cmd.div_sel  = DIV_SIZE;
      cmd.kind     = KIND_HEADER;
      cmd.status   = ST_VALID;
      unique case (state_ff)
         S_IDLE:    cmd.accept = start;
         S_H_MAGIC: begin cmd.word_req = 1'b1; cmd.word_sel = W_MAGIC;     end
         S_H_MCHK:  cmd.swap_set = 1'b1;
         S_H_KT:    begin cmd.word_req = 1'b1; cmd.word_sel = W_KEY_TAB;   end
         S_H_VT:    begin cmd.word_req = 1'b1; cmd.word_sel = W_VAL_TAB;   end
         S_H_HS:    begin cmd.word_req = 1'b1; cmd.word_sel = W_HASH_SIZE; end
         S_H_HB:    begin cmd.word_req = 1'b1; cmd.word_sel = W_HASH_TAB;  end
         S_H_OK: begin
            cmd.cat_set = 1'b1;
            cmd.emit    = 1'b1;
         end
         S_H_BAD: begin
            cmd.cat_clear = 1'b1;
            cmd.emit      = 1'b1;
            cmd.status    = ST_BAD_MAGIC;
         end
         S_H_SMALL: begin
            cmd.cat_clear = 1'b1;
            cmd.emit      = 1'b1;
            cmd.status    = ST_SMALL_HASH;
         end
         S_L_START: ;
         S_L_DIV1:  begin cmd.div_req = 1'b1; cmd.div_sel = DIV_SIZE;    end
         S_L_DIV2:  begin cmd.div_req = 1'b1; cmd.div_sel = DIV_SIZE_M2; end
         S_L_SLOT:  begin cmd.word_req = 1'b1; cmd.word_sel = W_SLOT;    end
         S_L_SCHK:  ;
         S_L_KOFF:  begin cmd.word_req = 1'b1; cmd.word_sel = W_KEY_OFF; end
         S_L_CMP:   cmd.cmp_req = 1'b1;
         S_L_ADV:   cmd.adv = 1'b1;
         S_L_VOFF:  begin cmd.word_req = 1'b1; cmd.word_sel = W_VAL_OFF; end
         S_L_HIT: begin
            cmd.emit      = 1'b1;
            cmd.kind      = KIND_LOOKUP;
            cmd.found     = 1'b1;
            cmd.key_clear = 1'b1;
         end
         S_L_MISS: begin
            cmd.emit      = 1'b1;
            cmd.kind      = KIND_LOOKUP;
            cmd.key_clear = 1'b1;
         end
         default: ;
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   // A result always ends the operation.
   `MCL_ASSERT_NXT(a_emit_idle, clock, reset, cmd.emit, state_ff == S_IDLE, "result not final")
   // A header check or a final key byte makes the block busy.
   `MCL_ASSERT_NXT(a_op_busy, clock, reset,
      cmd.accept && ((req_data.op == OP_HEADER) || ((req_data.op == OP_KEY) && req_data.last)),
      busy, "operation did not start")
   // The word reader and the comparator never share the image port.
   `MCL_ASSERT_IMP(a_port_excl, clock, reset, cmd.word_req, !cmd.cmp_req,
      "image port conflict")

endmodule

// ===== src/mo_catalog_hash_lookup_top.sv =====
// ----------------------------------------------------------------------------
// mo_catalog_hash_lookup_top
// Catalog image store with header check and hashed key lookup.
// ----------------------------------------------------------------------------
// Use: an operation is transferred when start is high and busy is low.
// Op 0 writes one image byte and op 1 buffers one key byte; both give no
// result and may follow each other in every cycle. Op 2 checks the
// header: its four-byte words are read one after another on the image
// store's single read port, and a bad magic word ends the check after the
// first word. A key byte marked last starts the lookup: it misses when the
// catalog is invalid or the key overflowed, otherwise two remainder
// divisions set the first slot and the step; each probe reads a slot word
// and a key offset and compares the key byte by byte (an empty slot ends
// the lookup), and a hit adds one more word read for the value offset.
// Each result is shown for exactly one cycle on rsp_data with rsp_strobe
// high; the receiver cannot stall it. Reset invalidates the catalog and
// clears the key; the image store keeps no reset value and must be written
// before it is read.
// ----------------------------------------------------------------------------
module mo_catalog_hash_lookup_top #(
   parameter int IMAGE_BYTES = mcl_pkg::IMAGE_BYTES_DEF,
   parameter int MAX_KEY     = mcl_pkg::MAX_KEY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  mcl_pkg::req_type req_data,
   output logic             rsp_strobe,
   output mcl_pkg::rsp_type rsp_data
);
   import mcl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // Sequencer.
   mcl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_data (req_data),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Stores and arithmetic.
   mcl_dp #(.IMAGE_BYTES(IMAGE_BYTES), .MAX_KEY(MAX_KEY)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   assign rsp_strobe = cmd.emit;

endmodule
